@@ rtl/core/sll_pkg.sv @@
// Shared types and codes for the sorted list with cursor.
package sll_pkg;

	localparam int KEY_W = 16;
	localparam int TAG_W = 32;
	localparam int OP_W  = 3;
	localparam int CNT_W = 5;

	localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_W-1:0] OP_READ   = 3'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
	localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
	localparam logic [OP_W-1:0] OP_REWIND = 3'd4;
	localparam logic [OP_W-1:0] OP_TO_END = 3'd5;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} req_item_t;

	typedef struct packed {
		logic             ok;
		logic             valid_res;
		logic [KEY_W-1:0] cur_key;
		logic [TAG_W-1:0] cur_tag;
		logic             at_end;
		logic             is_empty;
		logic [CNT_W-1:0] entry_count;
	} rsp_item_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t new_ent;
	} cell_ctl_t;

endpackage

@@ rtl/core/sorted_list_with_cursor_unit.sv @@
// Top level of the sorted list with cursor: control, cursor, cell row and result register.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | req_item_t (op, key, tag)
//   rsp     | out       | rsp_valid, rsp_stall | rsp_item_t (ok, ..., entry_count)
//
// An item updates the cell row and cursor at the edge it is accepted; the result is
// read from the cells into the output register once the pending slot can load it.
// With no stall on rsp, one item is accepted per cycle.
// The single pending result slot sets the rate: req_stall rises while it cannot drain.
// Reset empties the table at once and puts the cursor at the start.
module sorted_list_with_cursor_unit
	import sll_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int CW = $clog2(DEPTH+1);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	logic [CW-1:0] count_q, cursor_q;
	logic          pend_q, pend_ok_q, rsp_valid_q;
	rsp_item_t     rsp_q;

	cell_ctl_t     ctl;
	entry_t        ents [DEPTH];
	entry_t        rds  [DEPTH];
	logic [DEPTH-1:0] lts, firsts;

	logic          accept, load;
	logic          has_cur;
	logic [PW-1:0] ins_pos;
	entry_t        rd_all;
	logic          ok_d;
	logic [CW-1:0] count_d, cursor_d;

	assign load      = pend_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = pend_q && !load;
	assign accept    = req_valid && !req_stall;
	assign has_cur   = cursor_q < count_q;

	assign ctl.ins     = accept && req.op == OP_INSERT && count_q != FULL;
	assign ctl.rem     = accept && req.op == OP_REMOVE && has_cur;
	assign ctl.new_ent = '{key: req.key, tag: req.tag};

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			sll_cell #(
				.DEPTH(DEPTH),
				.IDX  (gi)
			) u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.cursor  (cursor_q),
				.count   (count_q),
				.prev_lt ((gi == 0) ? 1'b1 : lts[(gi == 0) ? 0 : gi-1]),
				.prev_ent((gi == 0) ? entry_t'('0) : ents[(gi == 0) ? 0 : gi-1]),
				.next_ent((gi == DEPTH-1) ? entry_t'('0) : ents[(gi == DEPTH-1) ? gi : gi+1]),
				.ent     (ents[gi]),
				.lt      (lts[gi]),
				.first   (firsts[gi]),
				.rd      (rds[gi])
			);
		end
	endgenerate

	always_comb begin
		ins_pos = '0;
		rd_all  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (firsts[i]) begin
				ins_pos = ins_pos | PW'(i);
			end
			rd_all = rd_all | rds[i];
		end
	end

	always_comb begin
		ok_d     = 1'b1;
		count_d  = count_q;
		cursor_d = cursor_q;
		unique case (req.op)
			OP_INSERT: begin
				if (count_q != FULL) begin
					count_d  = count_q + 1'b1;
					cursor_d = CW'(ins_pos) + 1'b1;
				end else begin
					ok_d = 1'b0;
				end
			end
			OP_READ: begin
			end
			OP_REMOVE: begin
				if (has_cur) begin
					count_d = count_q - 1'b1;
				end else begin
					ok_d = 1'b0;
				end
			end
			OP_NEXT: begin
				if (has_cur) begin
					cursor_d = cursor_q + 1'b1;
				end else begin
					ok_d = 1'b0;
				end
			end
			OP_REWIND: cursor_d = '0;
			OP_TO_END: cursor_d = count_q;
			default:   ok_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cursor_q    <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_d;
				cursor_q <= cursor_d;
			end
			if (accept) begin
				pend_q <= 1'b1;
			end else if (load) begin
				pend_q <= 1'b0;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_ok_q <= ok_d;
		end
		if (load) begin
			rsp_q.ok          <= pend_ok_q;
			rsp_q.valid_res   <= has_cur;
			rsp_q.cur_key     <= rd_all.key;
			rsp_q.cur_tag     <= rd_all.tag;
			rsp_q.at_end      <= !has_cur;
			rsp_q.is_empty    <= count_q == '0;
			rsp_q.entry_count <= CNT_W'(count_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("entry count exceeds table depth");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= count_q)
		else $error("cursor beyond the end of the list");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> count_q == $past(count_q) + 1'b1)
		else $error("successful insert did not add an entry");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.at_end |-> rsp_q.cur_key == '0 && rsp_q.cur_tag == '0)
		else $error("result at end carries a nonzero entry");

endmodule

@@ rtl/core/sll_cell.sv @@
// One storage cell of the sorted list: holds an entry and shifts with its neighbors.
module sll_cell
	import sll_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int IDX   = 0
) (
	input  logic                           clk,
	input  cell_ctl_t                      ctl,
	input  logic [$clog2(DEPTH+1)-1:0]     cursor,
	input  logic [$clog2(DEPTH+1)-1:0]     count,
	input  logic                           prev_lt,
	input  entry_t                         prev_ent,
	input  entry_t                         next_ent,
	output entry_t                         ent,
	output logic                           lt,
	output logic                           first,
	output entry_t                         rd
);

	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW-1:0] MY_IDX = CW'(IDX);
	localparam logic HAS_NEXT = (IDX < DEPTH-1);

	entry_t ent_q;
	logic   used;

	assign used  = MY_IDX < count;
	assign lt    = used && (ent_q.key < ctl.new_ent.key);
	assign first = !lt && prev_lt;
	assign ent   = ent_q;
	assign rd    = (used && MY_IDX == cursor) ? ent_q : '0;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!lt) begin
				ent_q <= first ? ctl.new_ent : prev_ent;
			end
		end else if (ctl.rem && HAS_NEXT && MY_IDX >= cursor) begin
			ent_q <= next_ent;
		end
	end

endmodule

@@ tb/tb_sorted_list_with_cursor_unit.sv @@
// Self-checking testbench for the sorted list with cursor, with a predicting model and random flow control.
module tb_sorted_list_with_cursor_unit;
	import sll_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 16;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 900;
	localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	req_item_t op_backlog[$];
	rsp_item_t due_results[$];

	logic [KEY_W-1:0] list_keys[DEPTH];
	logic [TAG_W-1:0] list_tags[DEPTH];
	int               list_count = 0;
	int               list_cursor = 0;

	int        mismatches = 0;
	int        results_seen = 0;
	int        idle_cycles = 0;
	int        req_gap = 0;
	bit        req_quiet = 1'b0;
	int        rsp_hold = 0;
	bit        rsp_quiet = 1'b0;
	int        press_left = 0;
	rsp_item_t want;

	sorted_list_with_cursor_unit #(.DEPTH(DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic rsp_item_t list_apply(req_item_t it);
		rsp_item_t r;
		logic      ok;
		int        pos;
		int        i;
		r = '0;
		ok = 1'b1;
		pos = 0;
		case (it.op)
			OP_INSERT: begin
				if (list_count >= DEPTH) begin
					ok = 1'b0;
				end else begin
					while (pos < list_count && it.key > list_keys[pos])
						pos++;
					for (i = list_count; i > pos; i--) begin
						list_keys[i] = list_keys[i-1];
						list_tags[i] = list_tags[i-1];
					end
					list_keys[pos] = it.key;
					list_tags[pos] = it.tag;
					list_count++;
					list_cursor = pos + 1;
				end
			end
			OP_READ: begin
			end
			OP_REMOVE: begin
				if (list_cursor >= list_count) begin
					ok = 1'b0;
				end else begin
					for (i = list_cursor; i + 1 < list_count; i++) begin
						list_keys[i] = list_keys[i+1];
						list_tags[i] = list_tags[i+1];
					end
					list_count--;
				end
			end
			OP_NEXT: begin
				if (list_cursor < list_count)
					list_cursor++;
				else
					ok = 1'b0;
			end
			OP_REWIND: list_cursor = 0;
			OP_TO_END: list_cursor = list_count;
			default: ok = 1'b0;
		endcase
		if (list_cursor > list_count)
			list_cursor = list_count;
		r.ok = ok;
		r.valid_res = (list_cursor < list_count);
		if (r.valid_res) begin
			r.cur_key = list_keys[list_cursor];
			r.cur_tag = list_tags[list_cursor];
		end
		r.at_end = !r.valid_res;
		r.is_empty = (list_count == 0);
		r.entry_count = CNT_W'(list_count);
		return r;
	endfunction

	function automatic req_item_t mk_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
			logic [TAG_W-1:0] tag);
		req_item_t it;
		it.op = op;
		it.key = key;
		it.tag = tag;
		return it;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		logic [KEY_W-1:0] k;
		case ($urandom_range(0, 3))
			0: k = KEY_W'($urandom_range(0, 7));
			1: k = 16'hFFFF - KEY_W'($urandom_range(0, 3));
			default: k = KEY_W'($urandom);
		endcase
		return k;
	endfunction

	function automatic logic [OP_W-1:0] pick_op();
		int r;
		logic [OP_W-1:0] op;
		r = $urandom_range(0, 199);
		if (r < 70) op = OP_INSERT;
		else if (r < 100) op = OP_READ;
		else if (r < 130) op = OP_REMOVE;
		else if (r < 170) op = OP_NEXT;
		else if (r < 184) op = OP_REWIND;
		else if (r < 198) op = OP_TO_END;
		else if (r == 198) op = OP_SPARE_A;
		else op = OP_SPARE_B;
		return op;
	endfunction

	task automatic note_field(string fname, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d: %s expected %h, got %h", results_seen, fname, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall)
				due_results.push_back(list_apply(req));
			if (!req_valid || !req_stall) begin
				if (req_gap > 0) begin
					req_gap--;
					req_valid <= 1'b0;
				end else if (op_backlog.size() != 0) begin
					req <= op_backlog.pop_front();
					req_valid <= 1'b1;
					req_gap = req_quiet ? 0 : $urandom_range(0, 4);
					if ($urandom_range(0, 39) == 0)
						req_quiet = !req_quiet;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: no item outstanding, got %h", results_seen, rsp);
				end else begin
					want = due_results.pop_front();
					note_field("ok", want.ok, rsp.ok);
					note_field("valid_res", want.valid_res, rsp.valid_res);
					note_field("cur_key", want.cur_key, rsp.cur_key);
					note_field("cur_tag", want.cur_tag, rsp.cur_tag);
					note_field("at_end", want.at_end, rsp.at_end);
					note_field("is_empty", want.is_empty, rsp.is_empty);
					note_field("entry_count", want.entry_count, rsp.entry_count);
				end
				results_seen++;
				rsp_hold = rsp_quiet ? 0 : $urandom_range(0, 4);
				if ($urandom_range(0, 39) == 0)
					rsp_quiet = !rsp_quiet;
				if (results_seen == 300)
					press_left = 120;
			end else if (rsp_hold > 0) begin
				rsp_hold--;
			end
			if (press_left > 0)
				press_left--;
			rsp_stall <= (rsp_hold != 0) || (press_left != 0);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_sorted_list_with_cursor_unit NOT OK");
			$finish;
		end
	end

	initial begin
		int n;
		int base;
		op_backlog.push_back(mk_item(OP_READ, '0, '0));
		op_backlog.push_back(mk_item(OP_REMOVE, '0, '0));
		op_backlog.push_back(mk_item(OP_NEXT, '0, '0));
		op_backlog.push_back(mk_item(OP_REWIND, '0, '0));
		op_backlog.push_back(mk_item(OP_TO_END, '0, '0));
		op_backlog.push_back(mk_item(OP_INSERT, 16'h1234, 32'hA5A5_0001));
		op_backlog.push_back(mk_item(OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF));
		op_backlog.push_back(mk_item(OP_INSERT, 16'h0000, 32'h0000_0000));
		op_backlog.push_back(mk_item(OP_INSERT, 16'h1234, 32'h5A5A_0002));
		op_backlog.push_back(mk_item(OP_READ, 16'hFFFF, 32'hFFFF_FFFF));
		op_backlog.push_back(mk_item(OP_REWIND, '0, '0));
		op_backlog.push_back(mk_item(OP_READ, '0, '0));
		repeat (4) op_backlog.push_back(mk_item(OP_NEXT, '0, '0));
		op_backlog.push_back(mk_item(OP_NEXT, '0, '0));
		op_backlog.push_back(mk_item(OP_REMOVE, '0, '0));
		op_backlog.push_back(mk_item(OP_REWIND, '0, '0));
		op_backlog.push_back(mk_item(OP_REMOVE, '0, '0));
		op_backlog.push_back(mk_item(OP_TO_END, '0, '0));
		op_backlog.push_back(mk_item(OP_SPARE_A, 16'hFFFF, 32'hFFFF_FFFF));
		op_backlog.push_back(mk_item(OP_SPARE_B, '0, '0));
		base = op_backlog.size();
		while (op_backlog.size() < base + RANDOM_ITEMS) begin
			n = $urandom_range(4, 20);
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					repeat (n) op_backlog.push_back(mk_item(OP_INSERT, pick_key(), $urandom));
				end
				3, 4: begin
					op_backlog.push_back(mk_item(OP_REWIND, pick_key(), $urandom));
					repeat (n) begin
						if ($urandom_range(0, 3) == 0)
							op_backlog.push_back(mk_item(OP_READ, pick_key(), $urandom));
						op_backlog.push_back(mk_item(OP_REMOVE, pick_key(), $urandom));
					end
				end
				5: begin
					op_backlog.push_back(mk_item(OP_REWIND, pick_key(), $urandom));
					repeat (n) begin
						op_backlog.push_back(mk_item(($urandom_range(0, 2) == 0) ? OP_READ : OP_NEXT,
							pick_key(), $urandom));
					end
				end
				default: begin
					repeat (n) op_backlog.push_back(mk_item(pick_op(), pick_key(), $urandom));
				end
			endcase
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (op_backlog.size() != 0 || req_valid)
			@(negedge clk);
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("tb_sorted_list_with_cursor_unit OK");
		else
			$display("tb_sorted_list_with_cursor_unit NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/sll_pkg.sv
rtl/core/sll_cell.sv
rtl/core/sorted_list_with_cursor_unit.sv
tb/tb_sorted_list_with_cursor_unit.sv
